>>> hdl/sfr_pkg.sv
package sfr_pkg;

   // byte codes
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_M      = 8'h4D;
   localparam logic [7:0] CH_P      = 8'h50;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   // receiver modes
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_CMD  = 2'd1;
   localparam logic [1:0] MODE_DATA = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_STOP  = 2'd1;
   localparam logic [1:0] KIND_HAND  = 2'd2;

   localparam int unsigned CMD_MAX_DEFAULT = 8;
   localparam int unsigned CMD_KEEP        = 4;
   localparam int unsigned DATA_LEN        = 14;
   localparam int unsigned FILL_W          = 4;
   localparam int unsigned FINGER_W        = 16;
   localparam int unsigned RSP_DATA_W      = 5 * FINGER_W;

   typedef logic [7:0] byte_type;

endpackage

>>> hdl/serial_frame_receiver_core.sv
// A result word is registered and appears on rsp_ in the cycle after the closing byte is taken.
// Throughput: one byte word per cycle; req_tready drops only while a result
// word waits in the output register and rsp_tready is low.
// Reset (synchronous, active high) returns to idle, clears the fill count,
// both byte stores and the output valid.
module serial_frame_receiver_core #(
   parameter int unsigned CMD_MAX = sfr_pkg::CMD_MAX_DEFAULT   // 4..15
) (
   input  logic                            clock,
   input  logic                            reset,
   // byte input
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] rx_byte
   // result output
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] little_finger, [31:16] ring_finger, [47:32] middle_finger,
   // [63:48] index_finger, [79:64] thumb
   output logic [sfr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [1:0]                      rsp_tuser   // [1:0] kind
);

   logic [1:0]                      mode_ff, mode_in;
   logic [sfr_pkg::FILL_W-1:0]      fill_ff, fill_in;
   sfr_pkg::byte_type               cmd_ff  [sfr_pkg::CMD_KEEP];
   sfr_pkg::byte_type               cmd_in  [sfr_pkg::CMD_KEEP];
   sfr_pkg::byte_type               data_ff [sfr_pkg::DATA_LEN];
   sfr_pkg::byte_type               data_in [sfr_pkg::DATA_LEN];

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sfr_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [1:0]                      rsp_kind_ff, rsp_kind_in;

   logic                            accept;
   logic                            hit;        // this word closes a matching frame
   logic [1:0]                      hit_kind;
   logic [sfr_pkg::RSP_DATA_W-1:0]  hit_data;
   logic                            cmd_head_ok;
   logic                            commas_ok;

   // the output register frees up in the same cycle it is drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign cmd_head_ok = (cmd_ff[0] == sfr_pkg::CH_M) && (cmd_ff[1] == sfr_pkg::CH_P) &&
                        (cmd_ff[2] == sfr_pkg::CH_M);
   assign commas_ok   = (data_ff[2] == sfr_pkg::CH_COMMA) && (data_ff[5] == sfr_pkg::CH_COMMA) &&
                        (data_ff[8] == sfr_pkg::CH_COMMA) && (data_ff[11] == sfr_pkg::CH_COMMA);

   // frame state update and result decode for one accepted word
   always_comb begin
      mode_in  = mode_ff;
      fill_in  = fill_ff;
      cmd_in   = cmd_ff;
      data_in  = data_ff;
      hit      = 1'b0;
      hit_kind = sfr_pkg::KIND_START;
      hit_data = '0;
      case (mode_ff)
         sfr_pkg::MODE_CMD: begin
            if (req_tdata == sfr_pkg::CH_HASH) begin
               mode_in = sfr_pkg::MODE_IDLE;
               if (cmd_head_ok && cmd_ff[3] == sfr_pkg::CH_ONE) begin
                  hit      = 1'b1;
                  hit_kind = sfr_pkg::KIND_START;
               end else if (cmd_head_ok && cmd_ff[3] == sfr_pkg::CH_ZERO) begin
                  hit      = 1'b1;
                  hit_kind = sfr_pkg::KIND_STOP;
               end
            end else if (fill_ff >= sfr_pkg::FILL_W'(CMD_MAX)) begin
               // overflow: drop the byte
               mode_in = sfr_pkg::MODE_IDLE;
            end else begin
               // only the head of a command is kept; later bytes are counted
               if (fill_ff < sfr_pkg::FILL_W'(sfr_pkg::CMD_KEEP)) begin
                  cmd_in[fill_ff[1:0]] = req_tdata;
               end
               fill_in = fill_ff + sfr_pkg::FILL_W'(1);
            end
         end
         sfr_pkg::MODE_DATA: begin
            if (req_tdata == sfr_pkg::CH_DOLLAR) begin
               mode_in = sfr_pkg::MODE_IDLE;
               if (commas_ok) begin
                  hit      = 1'b1;
                  hit_kind = sfr_pkg::KIND_HAND;
                  hit_data = {data_ff[12], data_ff[13], data_ff[9], data_ff[10],
                              data_ff[6],  data_ff[7],  data_ff[3], data_ff[4],
                              data_ff[0],  data_ff[1]};
               end
            end else if (fill_ff >= sfr_pkg::FILL_W'(sfr_pkg::DATA_LEN)) begin
               mode_in = sfr_pkg::MODE_IDLE;
            end else begin
               data_in[fill_ff] = req_tdata;
               fill_in          = fill_ff + sfr_pkg::FILL_W'(1);
            end
         end
         default: begin
            // idle and the unused mode code
            mode_in = sfr_pkg::MODE_IDLE;
            if (req_tdata == sfr_pkg::CH_DOLLAR) begin
               fill_in = '0;
               mode_in = sfr_pkg::MODE_CMD;
            end else if (req_tdata == sfr_pkg::CH_HASH) begin
               fill_in = '0;
               mode_in = sfr_pkg::MODE_DATA;
            end
         end
      endcase
   end

   // output register: load on a hit, clear valid when drained
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept && hit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = hit_kind;
         rsp_data_in  = hit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= sfr_pkg::MODE_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < int'(sfr_pkg::CMD_KEEP); i++) begin
            cmd_ff[i] <= '0;
         end
         for (int i = 0; i < int'(sfr_pkg::DATA_LEN); i++) begin
            data_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff <= mode_in;
            fill_ff <= fill_in;
            cmd_ff  <= cmd_in;
            data_ff <= data_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hdl/sfr_checker.sv
module sfr_assertions (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [7:0]                      req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sfr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [1:0]                      rsp_tuser
);

   // a waiting result is not lost
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   // no byte is taken while a result is stuck in the output register
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("byte accepted over a stalled result");

   // a new result comes only from an accepted byte
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result without an input byte");

   // fingers are zero on command results
   a_cmd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != sfr_pkg::KIND_HAND |-> rsp_tdata == '0)
      else $error("command result carries finger data");

   // a fresh result is closed by the right delimiter
   a_closer: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && $past(req_tvalid && req_tready) && !$past(reset) |->
         ((rsp_tuser == sfr_pkg::KIND_HAND) && ($past(req_tdata) == sfr_pkg::CH_DOLLAR)) ||
         ((rsp_tuser != sfr_pkg::KIND_HAND) && ($past(req_tdata) == sfr_pkg::CH_HASH)))
      else $error("result kind does not match closing byte");

endmodule

bind serial_frame_receiver_core sfr_assertions u_sfr_assertions (.*);
